[rtl/rlss_pkg.sv]
// Shared types, constants and the weight table for the random looping shift sequencer.
// Used by rlss_rotate, rlss_weight_sum and random_looping_shift_sequencer_core.
package rlss_pkg;

   // Default loop register width and the fixed width of the rotation and weight logic.
   localparam int REG_BITS_DEF = 16;
   localparam int LANE_BITS    = 16;

   localparam logic [19:0] CV_MAX = 20'd655360;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_LOOP_LENGTH = 3'd0,
      CSR_OUTPUT_SCALE = 3'd1,
      CSR_WEIGHT_PROG = 3'd2,
      CSR_WIDE_RES = 3'd3,
      CSR_TRIG_MODE = 3'd4,
      CSR_SKIP_RESET = 3'd5,
      CSR_PULSE_TICKS = 3'd6
   } csr_index_type;

   // Trigger output modes.
   localparam logic [1:0] TRIG_PULSE = 2'd0;
   localparam logic [1:0] TRIG_GATE  = 2'd1;
   localparam logic [1:0] TRIG_CLOCK = 2'd2;

   // Configuration reset values.
   localparam logic [4:0]  LOOP_LENGTH_RST = 5'd8;
   localparam logic [16:0] OUTPUT_SCALE_RST = 17'd65536;
   localparam logic [15:0] PULSE_TICKS_RST = 16'd48;

   // Selects the weight set for the voltage sum.
   typedef struct packed {
      logic [1:0] progression;
      logic       wide;
   } weight_sel_type;

   // Weights in volts scaled by 65536; index is progression*32 + wide*16 + bit.
   localparam logic [18:0] WEIGHT_ROM [128] = '{
      19'd2570, 19'd5141, 19'd10281, 19'd20563, 19'd41125, 19'd82250, 19'd164501, 19'd329001,
      19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
      19'd10, 19'd20, 19'd40, 19'd80, 19'd160, 19'd320, 19'd640, 19'd1280,
      19'd2560, 19'd5120, 19'd10240, 19'd20480, 19'd40961, 19'd81921, 19'd163843, 19'd327685,
      19'd8809, 19'd14254, 19'd23063, 19'd37316, 19'd60379, 19'd97695, 19'd158074, 19'd255770,
      19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
      19'd184, 19'd297, 19'd481, 19'd778, 19'd1258, 19'd2036, 19'd3295, 19'd5331,
      19'd8626, 19'd13957, 19'd22583, 19'd36540, 19'd59123, 19'd95662, 19'd154785, 19'd250447,
      19'd27470, 19'd35710, 19'd46424, 19'd60351, 19'd78456, 19'd101993, 19'd132590, 19'd172367,
      19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
      19'd3000, 19'd3900, 19'd5070, 19'd6590, 19'd8568, 19'd11138, 19'd14479, 19'd18823,
      19'd24470, 19'd31811, 19'd41354, 19'd53760, 19'd69888, 19'd90855, 19'd118111, 19'd153544,
      19'd7533, 19'd15066, 19'd22599, 19'd37664, 19'd60263, 19'd97927, 19'd158190, 19'd256118,
      19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
      19'd157, 19'd314, 19'd470, 19'd784, 19'd1255, 19'd2039, 19'd3293, 19'd5332,
      19'd8625, 19'd13957, 19'd22582, 19'd36540, 19'd59122, 19'd95662, 19'd154784, 19'd250445
   };

endpackage

[rtl/random_looping_shift_sequencer_core.sv]
// Random looping shift sequencer: per-tick state update, weighted voltage sum and scaling.
// Depends on rlss_pkg, rlss_rotate and rlss_weight_sum.
//
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/stall    clock, reset, clear levels, control, random
//  rsp      out        rsp_valid/stall    cv_out, trig_out, pattern, step_position
//  csr      in         csr_write          csr_index, csr_wdata
//
// One request is taken each cycle unless stalled; its response follows via s1 and s2.
// The loop state updates as the request is taken; the adder tree over the weight
// table and the 20 x 17 bit scaling multiply each own one stage.
// Reset is synchronous and clears the loop state and restores register defaults.
// A stall on the response side holds the whole pipeline and stalls the request side.
module random_looping_shift_sequencer_core
   import rlss_pkg::*;
#(
   parameter int REGISTER_BITS = REG_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_clock_high,
   input  logic               req_reset_high,
   input  logic               req_clear_high,
   input  logic signed [10:0] req_control_milli,
   input  logic [3:0]         req_random_digit,
   input  logic               req_random_bit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_cv_out,
   output logic               rsp_trig_out,
   output logic [15:0]        rsp_pattern,
   output logic [3:0]         rsp_step_position,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_wdata
);

   // Configuration registers.
   logic [4:0]  loop_length_ff;
   logic [16:0] output_scale_ff;
   logic [1:0]  weight_prog_ff;
   logic        wide_res_ff;
   logic [1:0]  trig_mode_ff;
   logic        skip_reset_ff;
   logic [15:0] pulse_ticks_ff;

   // Loop and trigger state with next values.
   logic [REGISTER_BITS-1:0] loop_bits_ff, loop_bits_in;
   logic [3:0]  start_step_ff, start_step_in;
   logic        prev_clk_ff, prev_rst_ff, prev_clr_ff;
   logic        skip_pending_ff, skip_pending_in;
   logic        pulse_active_ff, pulse_active_in;
   logic [15:0] pulse_left_ff, pulse_left_in;
   logic        gate_level_ff, gate_level_in;
   logic        trig_level_ff, trig_level_in;
   logic        recompute_in;

   // Pipeline registers.
   logic                     s1_valid_ff;
   logic [REGISTER_BITS-1:0] s1_loop_ff;
   logic                     s1_recompute_ff;
   logic                     s1_trig_ff;
   logic [3:0]               s1_step_ff;
   logic                     s2_valid_ff;
   logic [REGISTER_BITS-1:0] s2_pattern_ff;
   logic                     s2_trig_ff;
   logic [3:0]               s2_step_ff;
   logic [19:0]              voltage_sum_ff;
   logic                     rsp_valid_ff;
   logic [19:0]              rsp_cv_ff;
   logic                     rsp_trig_ff;
   logic [15:0]              rsp_pattern_ff;
   logic [3:0]               rsp_step_ff;

   logic advance;
   logic req_accept;

   // Update datapath signals.
   logic                 clk_edge, rst_edge, clr_edge;
   logic [4:0]           eff_len;
   logic [LANE_BITS-1:0] bits_a16;
   logic [LANE_BITS-1:0] rotated16;
   logic [LANE_BITS-1:0] bits_b16;
   logic                 ctrl_neg;
   logic [10:0]          ctrl_abs;
   logic [10:0]          ctrl_mag;
   logic [10:0]          digit_thr;
   logic                 pick_random;
   logic                 new_bit;
   logic [4:0]           step_inc;

   // Voltage stages.
   weight_sel_type weight_sel;
   logic [19:0]    sum_next;
   logic [36:0]    product;
   logic [37:0]    rounded;
   logic [21:0]    scaled;
   logic [19:0]    cv_next;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_length_ff  <= LOOP_LENGTH_RST;
         output_scale_ff <= OUTPUT_SCALE_RST;
         weight_prog_ff  <= 2'd0;
         wide_res_ff     <= 1'b0;
         trig_mode_ff    <= TRIG_PULSE;
         skip_reset_ff   <= 1'b1;
         pulse_ticks_ff  <= PULSE_TICKS_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_LOOP_LENGTH:  loop_length_ff  <= csr_wdata[4:0];
            CSR_OUTPUT_SCALE: output_scale_ff <= csr_wdata;
            CSR_WEIGHT_PROG:  weight_prog_ff  <= csr_wdata[1:0];
            CSR_WIDE_RES:     wide_res_ff     <= csr_wdata[0];
            CSR_TRIG_MODE:    trig_mode_ff    <= csr_wdata[1:0];
            CSR_SKIP_RESET:   skip_reset_ff   <= csr_wdata[0];
            CSR_PULSE_TICKS:  pulse_ticks_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign clk_edge = req_clock_high && !prev_clk_ff;
   assign rst_edge = req_reset_high && !prev_rst_ff;
   assign clr_edge = req_clear_high && !prev_clr_ff;

   always_comb begin
      if (loop_length_ff == 5'd0) begin
         eff_len = 5'd1;
      end else if (loop_length_ff > 5'(REGISTER_BITS)) begin
         eff_len = 5'(REGISTER_BITS);
      end else begin
         eff_len = loop_length_ff;
      end
   end

   assign bits_a16 = clr_edge ? '0 : LANE_BITS'(loop_bits_ff);

   rlss_rotate u_rotate (
      .loop_in    (bits_a16),
      .start_step (start_step_ff),
      .loop_len   (eff_len),
      .rotated    (rotated16)
   );

   assign bits_b16 = rst_edge ? LANE_BITS'(rotated16[REGISTER_BITS-1:0]) : bits_a16;

   // The random bit wins when the digit exceeds the control magnitude in tenths,
   // that is when the magnitude is below 100 times the digit.
   assign ctrl_neg    = req_control_milli[10];
   assign ctrl_abs    = ctrl_neg ? 11'(-req_control_milli) : 11'(req_control_milli);
   assign ctrl_mag    = (ctrl_abs > 11'd1000) ? 11'd1000 : ctrl_abs;
   assign digit_thr   = 11'(req_random_digit) * 11'd100;
   assign pick_random = ctrl_mag < digit_thr;
   assign new_bit     = pick_random ? req_random_bit
                                    : (bits_b16[4'(eff_len - 5'd1)] ^ ctrl_neg);

   always_comb begin
      loop_bits_in    = bits_b16[REGISTER_BITS-1:0];
      start_step_in   = rst_edge ? 4'd0 : start_step_ff;
      skip_pending_in = (rst_edge && skip_reset_ff) ? 1'b1 : skip_pending_ff;
      pulse_active_in = pulse_active_ff;
      pulse_left_in   = pulse_left_ff;
      gate_level_in   = gate_level_ff;
      trig_level_in   = trig_level_ff;
      recompute_in    = clr_edge || rst_edge;
      step_inc        = {1'b0, start_step_in} + 5'd1;

      if (clk_edge) begin
         if (skip_pending_in) begin
            skip_pending_in = 1'b0;
         end else begin
            start_step_in = (step_inc >= eff_len) ? 4'd0 : step_inc[3:0];
            loop_bits_in  = {bits_b16[REGISTER_BITS-2:0], new_bit};
            recompute_in  = 1'b1;
            if (new_bit) begin
               pulse_active_in = 1'b1;
               pulse_left_in   = pulse_ticks_ff;
               if (trig_mode_ff == TRIG_GATE) begin
                  gate_level_in = 1'b1;
               end
            end else if (trig_mode_ff == TRIG_GATE) begin
               gate_level_in = 1'b0;
               trig_level_in = 1'b0;
            end
         end
      end

      if (pulse_active_in) begin
         case (trig_mode_ff)
            TRIG_PULSE: begin
               if (pulse_left_in == 16'd0) begin
                  pulse_active_in = 1'b0;
                  trig_level_in   = 1'b0;
               end else begin
                  pulse_left_in = pulse_left_in - 16'd1;
                  trig_level_in = 1'b1;
               end
            end
            TRIG_CLOCK: begin
               trig_level_in = req_clock_high;
               if (!req_clock_high) begin
                  pulse_active_in = 1'b0;
               end
            end
            TRIG_GATE: trig_level_in = gate_level_in;
            default: ;
         endcase
      end
   end

   // Loop state advances with each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_bits_ff    <= '0;
         start_step_ff   <= 4'd0;
         prev_clk_ff     <= 1'b0;
         prev_rst_ff     <= 1'b0;
         prev_clr_ff     <= 1'b0;
         skip_pending_ff <= 1'b0;
         pulse_active_ff <= 1'b0;
         pulse_left_ff   <= 16'd0;
         gate_level_ff   <= 1'b0;
         trig_level_ff   <= 1'b0;
      end else if (req_accept) begin
         loop_bits_ff    <= loop_bits_in;
         start_step_ff   <= start_step_in;
         prev_clk_ff     <= req_clock_high;
         prev_rst_ff     <= req_reset_high;
         prev_clr_ff     <= req_clear_high;
         skip_pending_ff <= skip_pending_in;
         pulse_active_ff <= pulse_active_in;
         pulse_left_ff   <= pulse_left_in;
         gate_level_ff   <= gate_level_in;
         trig_level_ff   <= trig_level_in;
      end
   end

   assign weight_sel.progression = weight_prog_ff;
   assign weight_sel.wide        = wide_res_ff;

   rlss_weight_sum u_weight_sum (
      .pattern (LANE_BITS'(s1_loop_ff)),
      .sel     (weight_sel),
      .sum     (sum_next)
   );

   assign product = 37'(voltage_sum_ff) * 37'(output_scale_ff);
   assign rounded = 38'(product) + 38'd32768;
   assign scaled  = rounded[37:16];
   assign cv_next = (scaled > 22'(CV_MAX)) ? CV_MAX : scaled[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         voltage_sum_ff <= 20'd0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
         // The sum only moves on a clear, a reset or a taken clock edge.
         if (s1_valid_ff && s1_recompute_ff) begin
            voltage_sum_ff <= sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_loop_ff      <= loop_bits_in;
         s1_recompute_ff <= recompute_in;
         s1_trig_ff      <= trig_level_in;
         s1_step_ff      <= start_step_in;
         s2_pattern_ff   <= s1_loop_ff;
         s2_trig_ff      <= s1_trig_ff;
         s2_step_ff      <= s1_step_ff;
         rsp_cv_ff       <= cv_next;
         rsp_trig_ff     <= s2_trig_ff;
         rsp_pattern_ff  <= 16'(s2_pattern_ff);
         rsp_step_ff     <= s2_step_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cv_out        = rsp_cv_ff;
   assign rsp_trig_out      = rsp_trig_ff;
   assign rsp_pattern       = rsp_pattern_ff;
   assign rsp_step_position = rsp_step_ff;

endmodule

[rtl/rlss_rotate.sv]
// Loop rotation on a reset edge: moves a start step within the length to position 0.
// Depends on rlss_pkg for the lane width.
module rlss_rotate
   import rlss_pkg::*;
(
   input  logic [LANE_BITS-1:0] loop_in,
   input  logic [3:0]           start_step,
   input  logic [4:0]           loop_len,
   output logic [LANE_BITS-1:0] rotated
);

   logic [LANE_BITS-1:0]   len_mask;
   logic [LANE_BITS-1:0]   keep_mask;
   logic [2*LANE_BITS-1:0] ext0;
   logic [2*LANE_BITS-1:0] ext1;
   logic [2*LANE_BITS-1:0] ext2;
   logic [2*LANE_BITS-1:0] ext3;
   logic [2*LANE_BITS-1:0] ext4;
   logic [2*LANE_BITS-1:0] ext5;
   logic [2*LANE_BITS-1:0] fwd;
   logic [LANE_BITS-1:0]   back;
   logic                   in_range;

   assign len_mask  = LANE_BITS'((17'd1 << loop_len) - 17'd1);
   assign keep_mask = LANE_BITS'((17'd1 << start_step) - 17'd1);

   // Build the periodic extension of the loop by repeated doubling.
   assign ext0 = {{LANE_BITS{1'b0}}, loop_in & len_mask};
   assign ext1 = ext0 | (ext0 << {4'd0, loop_len});
   assign ext2 = ext1 | (ext1 << {3'd0, loop_len, 1'b0});
   assign ext3 = ext2 | (ext2 << {2'd0, loop_len, 2'b0});
   assign ext4 = ext3 | (ext3 << {1'd0, loop_len, 3'b0});
   assign ext5 = ext4 | (ext4 << {loop_len, 4'b0});

   assign in_range = {1'b0, start_step} < loop_len;
   assign fwd      = ext5 >> start_step;
   assign back     = ext5[LANE_BITS-1:0] << start_step;

   // A start step at or past the length leaves the low bits in place and
   // repeats the loop above them.
   assign rotated = in_range ? fwd[LANE_BITS-1:0]
                             : (loop_in & keep_mask) | (back & ~keep_mask);

endmodule

[rtl/rlss_weight_sum.sv]
// Weighted sum of the set bits of the loop register: the low 8, or all 16 when wide.
// Depends on rlss_pkg for the weight table and the selection struct.
module rlss_weight_sum
   import rlss_pkg::*;
(
   input  logic [LANE_BITS-1:0] pattern,
   input  weight_sel_type       sel,
   output logic [19:0]          sum
);

   logic [18:0] term [LANE_BITS];
   logic [20:0] group_sum [4];
   logic [22:0] total;

   always_comb begin
      for (int i = 0; i < LANE_BITS; i++) begin
         if (pattern[i] && (i < 8 || sel.wide)) begin
            term[i] = WEIGHT_ROM[{sel.progression, sel.wide, 4'(i)}];
         end else begin
            term[i] = 19'd0;
         end
      end
      for (int g = 0; g < 4; g++) begin
         group_sum[g] = 21'(term[4*g]) + 21'(term[4*g+1]) + 21'(term[4*g+2])
                        + 21'(term[4*g+3]);
      end
   end

   assign total = 23'(group_sum[0]) + 23'(group_sum[1]) + 23'(group_sum[2])
                  + 23'(group_sum[3]);
   assign sum   = total[19:0];

endmodule
